// ----- rtl/core/bwm_pkg.sv -----
// Shared types and constants for the banned word masker.
// Used by the controller, the datapath and the top level; depends on nothing.
package bwm_pkg;

  typedef enum logic [1:0] {
    CMD_TEXT   = 2'd0,
    CMD_END    = 2'd1,
    CMD_DICT   = 2'd2,
    CMD_COMMIT = 2'd3
  } cmd_e;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_start;
    logic meta_rd;
    logic next_word;
    logic cmp_start;
    logic cmp_rd;
    logic next_byte;
    logic set_hit;
    logic emit_start;
    logic emit_rd;
    logic emit_char;
    logic emit_space;
  } ctrl_cmd_t;

  // Conditions reported by the datapath to the controller.
  typedef struct packed {
    logic closes;
    logic scan_done;
    logic meta_match;
    logic byte_eq;
    logic byte_last;
    logic emit_done;
    logic out_free;
  } dp_status_t;

  function automatic logic is_delim(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_COMMA) || (b == CH_PERIOD) || (b == CH_HYPHEN);
  endfunction

endpackage

// ----- rtl/core/bwm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module bwm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bwm_ctrl.sv -----
// Controller state machine of the banned word masker.
// Depends on bwm_pkg; drives the datapath strobes and the input stall.
module bwm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  bwm_pkg::dp_status_t    status_i,
  output bwm_pkg::ctrl_cmd_t     ctrl_o
);
  import bwm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_META     = 8'b0000_0010,
    S_META_CHK = 8'b0000_0100,
    S_CMP_RD   = 8'b0000_1000,
    S_CMP_CHK  = 8'b0001_0000,
    S_EMIT_RD  = 8'b0010_0000,
    S_EMIT_WR  = 8'b0100_0000,
    S_EMIT_SP  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          if (status_i.closes) begin
            ctrl_o.scan_start = 1'b1;
            state_d           = S_META;
          end
        end
      end
      S_META: begin
        if (status_i.scan_done) begin
          ctrl_o.emit_start = 1'b1;
          state_d           = S_EMIT_RD;
        end else begin
          ctrl_o.meta_rd = 1'b1;
          state_d        = S_META_CHK;
        end
      end
      S_META_CHK: begin
        if (status_i.meta_match) begin
          ctrl_o.cmp_start = 1'b1;
          state_d          = S_CMP_RD;
        end else begin
          ctrl_o.next_word = 1'b1;
          state_d          = S_META;
        end
      end
      S_CMP_RD: begin
        ctrl_o.cmp_rd = 1'b1;
        state_d       = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        priority if (!status_i.byte_eq) begin
          ctrl_o.next_word = 1'b1;
          state_d          = S_META;
        end else if (status_i.byte_last) begin
          ctrl_o.set_hit    = 1'b1;
          ctrl_o.emit_start = 1'b1;
          state_d           = S_EMIT_RD;
        end else begin
          ctrl_o.next_byte = 1'b1;
          state_d          = S_CMP_RD;
        end
      end
      S_EMIT_RD: begin
        if (status_i.emit_done) begin
          state_d = S_EMIT_SP;
        end else begin
          ctrl_o.emit_rd = 1'b1;
          state_d        = S_EMIT_WR;
        end
      end
      S_EMIT_WR: begin
        if (status_i.out_free) begin
          ctrl_o.emit_char = 1'b1;
          ctrl_o.next_byte = 1'b1;
          state_d          = S_EMIT_RD;
        end
      end
      S_EMIT_SP: begin
        if (status_i.out_free) begin
          ctrl_o.emit_space = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/bwm_dp.sv -----
// Datapath of the banned word masker: token, word and length memories,
// counters, match flag and the output register. Depends on bwm_pkg and bwm_ram.
module bwm_dp #(
  parameter int unsigned MAX_TOKEN_LEN = 32,
  parameter int unsigned MAX_WORDS     = 16,
  parameter int unsigned MAX_WORD_LEN  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bwm_pkg::ctrl_cmd_t   ctrl_i,
  output bwm_pkg::dp_status_t  status_o,
  input  logic [1:0]           cmd_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [7:0]           out_byte_o,
  output logic                 last_o,
  output logic                 truncated_o
);
  import bwm_pkg::*;

  localparam int unsigned TLW    = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned TIW    = $clog2(MAX_TOKEN_LEN);
  localparam int unsigned WLW    = $clog2(MAX_WORD_LEN + 1);
  localparam int unsigned WIW    = $clog2(MAX_WORD_LEN);
  localparam int unsigned WCW    = $clog2(MAX_WORDS + 1);
  localparam int unsigned WAW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned LW     = (TLW > WLW) ? TLW : WLW;
  localparam int unsigned WDEPTH = MAX_WORDS * (2 ** WIW);
  localparam int unsigned WRAW   = $clog2(WDEPTH);

  logic [TLW-1:0] tok_len_q;
  logic           tok_ovf_q;
  logic [WCW-1:0] word_count_q;
  logic [WLW-1:0] load_len_q;
  logic           load_unus_q;
  logic [WCW-1:0] word_idx_q;
  logic [TLW-1:0] idx_q;
  logic           hit_q;
  logic           out_valid_q;
  logic [7:0]     out_byte_q;
  logic           out_last_q;
  logic           out_trunc_q;

  logic           delim;
  logic           tok_full, dict_full, load_full;
  logic           tok_we, dict_we, meta_we, dict_over;
  logic [7:0]     tok_rdata, word_rdata;
  logic [WLW:0]   meta_rdata;
  logic           out_free;

  assign delim     = is_delim(data_byte_i);
  assign tok_full  = (tok_len_q == TLW'(MAX_TOKEN_LEN));
  assign dict_full = (word_count_q == WCW'(MAX_WORDS));
  assign load_full = (load_len_q == WLW'(MAX_WORD_LEN));

  assign tok_we    = ctrl_i.accept && (cmd_i == CMD_TEXT) && !delim && !tok_full;
  assign dict_we   = ctrl_i.accept && (cmd_i == CMD_DICT) && !dict_full && !load_full;
  assign dict_over = ctrl_i.accept && (cmd_i == CMD_DICT) && !dict_full && load_full;
  assign meta_we   = ctrl_i.accept && (cmd_i == CMD_COMMIT) && !dict_full;

  bwm_ram #(.WIDTH(8), .DEPTH(MAX_TOKEN_LEN)) u_tok_ram (
    .clk_i   (clk_i),
    .we_i    (tok_we),
    .waddr_i (tok_len_q[TIW-1:0]),
    .wdata_i (data_byte_i),
    .re_i    (ctrl_i.cmp_rd || ctrl_i.emit_rd),
    .raddr_i (idx_q[TIW-1:0]),
    .rdata_o (tok_rdata)
  );

  // Each word owns a slot of a power-of-two number of bytes.
  bwm_ram #(.WIDTH(8), .DEPTH(WDEPTH)) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (WRAW'({word_count_q[WAW-1:0], load_len_q[WIW-1:0]})),
    .wdata_i (data_byte_i),
    .re_i    (ctrl_i.cmp_rd),
    .raddr_i (WRAW'({word_idx_q[WAW-1:0], WIW'(idx_q)})),
    .rdata_o (word_rdata)
  );

  // Per word: unusable flag above the committed length.
  bwm_ram #(.WIDTH(WLW + 1), .DEPTH(MAX_WORDS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (word_count_q[WAW-1:0]),
    .wdata_i ({load_unus_q, load_len_q}),
    .re_i    (ctrl_i.meta_rd),
    .raddr_i (word_idx_q[WAW-1:0]),
    .rdata_o (meta_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    status_o.closes     = (((cmd_i == CMD_TEXT) && delim) || (cmd_i == CMD_END)) &&
                          ((tok_len_q != '0) || tok_ovf_q);
    status_o.scan_done  = tok_ovf_q || (word_idx_q == word_count_q);
    status_o.meta_match = !meta_rdata[WLW] &&
                          (LW'(meta_rdata[WLW-1:0]) == LW'(tok_len_q));
    status_o.byte_eq    = (tok_rdata == word_rdata);
    status_o.byte_last  = ((idx_q + TLW'(1)) == tok_len_q);
    status_o.emit_done  = (idx_q == tok_len_q);
    status_o.out_free   = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_len_q    <= '0;
      tok_ovf_q    <= 1'b0;
      word_count_q <= '0;
      load_len_q   <= '0;
      load_unus_q  <= 1'b0;
      word_idx_q   <= '0;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (tok_we) begin
        tok_len_q <= tok_len_q + TLW'(1);
      end else if (ctrl_i.accept && (cmd_i == CMD_TEXT) && !delim) begin
        tok_ovf_q <= 1'b1;
      end
      if (ctrl_i.emit_space) begin
        tok_len_q <= '0;
        tok_ovf_q <= 1'b0;
      end

      if (dict_we) begin
        load_len_q <= load_len_q + WLW'(1);
      end
      if (dict_over) begin
        load_unus_q <= 1'b1;
      end
      if (meta_we) begin
        word_count_q <= word_count_q + WCW'(1);
        load_len_q   <= '0;
        load_unus_q  <= 1'b0;
      end

      if (ctrl_i.scan_start) begin
        word_idx_q <= '0;
        hit_q      <= 1'b0;
      end else if (ctrl_i.next_word) begin
        word_idx_q <= word_idx_q + WCW'(1);
      end
      if (ctrl_i.set_hit) begin
        hit_q <= 1'b1;
      end

      if (ctrl_i.cmp_start || ctrl_i.emit_start) begin
        idx_q <= '0;
      end else if (ctrl_i.next_byte) begin
        idx_q <= idx_q + TLW'(1);
      end

      if (ctrl_i.emit_char || ctrl_i.emit_space) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_char) begin
      out_byte_q  <= hit_q ? CH_STAR : tok_rdata;
      out_last_q  <= 1'b0;
      out_trunc_q <= tok_ovf_q;
    end else if (ctrl_i.emit_space) begin
      out_byte_q  <= CH_SPACE;
      out_last_q  <= 1'b1;
      out_trunc_q <= tok_ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;
  assign truncated_o = out_trunc_q;

endmodule

// ----- rtl/core/banned_word_masker.sv -----
// Top level of the banned word masker: controller plus datapath.
// Depends on bwm_pkg, bwm_ctrl, bwm_dp (and through it bwm_ram).
//
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------------
//   input   | in_valid_i / in_stall_o   | cmd_i[1:0], data_byte_i[7:0]
//   output  | out_valid_o / out_stall_i | out_byte_o[7:0], last_o, truncated_o
//
// A transaction that does not close a token is accepted in S_IDLE, which it keeps.
// A closing transaction is accepted, then scans the committed words, unless the token
// was truncated: each word passes S_META and S_META_CHK, and each usable word of the
// token's length has its bytes compared in S_CMP_RD and S_CMP_CHK; a scan with no
// match ends in S_META. Then each token byte passes S_EMIT_RD and S_EMIT_WR, and the
// trailing space S_EMIT_RD and S_EMIT_SP. The registered read of the token and word
// memories is why each read has a state of its own. Output stalls hold S_EMIT_WR and
// S_EMIT_SP; the output register lets the next transaction enter while the space waits.
// Reset clears only counters and control; memory contents are never read before
// they are written, so no clearing pass follows reset.
module banned_word_masker #(
  parameter int unsigned MAX_TOKEN_LEN = 32,
  parameter int unsigned MAX_WORDS     = 16,
  parameter int unsigned MAX_WORD_LEN  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       truncated_o
);
  import bwm_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  bwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  bwm_dp #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .MAX_WORDS     (MAX_WORDS),
    .MAX_WORD_LEN  (MAX_WORD_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .truncated_o (truncated_o)
  );

  // The output register is loaded only when its previous transaction has left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.emit_char || ctrl.emit_space) |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while stalled");

  // A scan starts only on an accepted input transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.scan_start |-> (in_valid_i && !in_stall_o))
    else $error("scan started without an input transaction");

  // Once the trailing space is loaded, the block takes input in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit_space |=> !in_stall_o)
    else $error("block not idle after the trailing space");

endmodule

// ----- bench/bwm_checker.sv -----
`timescale 1ns / 1ps
// Checker for banned_word_masker. It watches both channels, keeps its own copy of
// the token and dictionary state, and compares each output transaction in order.
// Depends on bwm_pkg for the command codes and character constants.
module bwm_checker #(
  parameter int unsigned MAX_TOKEN_LEN = 32,
  parameter int unsigned MAX_WORDS     = 16,
  parameter int unsigned MAX_WORD_LEN  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_i,
  input  logic        truncated_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import bwm_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       trunc;
  } masked_char_t;

  masked_char_t expected_chars [$];

  logic [7:0]  tok_bytes [MAX_TOKEN_LEN];
  int unsigned tok_len;
  bit          tok_cut;
  logic [7:0]  ban_bytes [MAX_WORDS][MAX_WORD_LEN];
  int unsigned ban_len [MAX_WORDS];
  bit          ban_bad [MAX_WORDS];
  int unsigned ban_count;
  int unsigned load_len;

  function automatic bit token_banned();
    int unsigned w;
    int unsigned i;
    bit same;
    if (tok_cut) return 1'b0;
    for (w = 0; w < ban_count; w++) begin
      if (ban_bad[w] || ban_len[w] != tok_len) continue;
      same = 1'b1;
      for (i = 0; i < tok_len; i++) begin
        if (ban_bytes[w][i] != tok_bytes[i]) same = 1'b0;
      end
      if (same) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Queues the whole run for the open token: its bytes or asterisks, then a
  // space that ends the run.
  task automatic close_token();
    masked_char_t c;
    bit hit;
    int unsigned i;
    hit = token_banned();
    for (i = 0; i < tok_len; i++) begin
      c.ch    = hit ? CH_STAR : tok_bytes[i];
      c.last  = 1'b0;
      c.trunc = tok_cut;
      expected_chars.push_back(c);
    end
    c.ch    = CH_SPACE;
    c.last  = 1'b1;
    c.trunc = tok_cut;
    expected_chars.push_back(c);
    tok_len = 0;
    tok_cut = 1'b0;
  endtask

  task automatic predict(input cmd_e c, input logic [7:0] b);
    case (c)
      CMD_TEXT: begin
        if (b inside {CH_SPACE, CH_COMMA, CH_PERIOD, CH_HYPHEN}) begin
          if (tok_len != 0 || tok_cut) close_token();
        end else if (tok_len < MAX_TOKEN_LEN) begin
          tok_bytes[tok_len] = b;
          tok_len++;
        end else begin
          tok_cut = 1'b1;
        end
      end
      CMD_END: begin
        if (tok_len != 0 || tok_cut) close_token();
      end
      CMD_DICT: begin
        if (ban_count < MAX_WORDS) begin
          if (load_len == 0) ban_bad[ban_count] = 1'b0;
          if (load_len < MAX_WORD_LEN) begin
            ban_bytes[ban_count][load_len] = b;
            load_len++;
          end else begin
            ban_bad[ban_count] = 1'b1;
          end
        end
      end
      CMD_COMMIT: begin
        if (ban_count < MAX_WORDS) begin
          if (load_len == 0) ban_bad[ban_count] = 1'b0;
          ban_len[ban_count] = load_len;
          ban_count++;
          load_len = 0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    masked_char_t want;
    masked_char_t seen;
    if (!rst_ni) begin
      expected_chars.delete();
      tok_len      = 0;
      tok_cut      = 1'b0;
      ban_count    = 0;
      load_len     = 0;
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      // Outputs are checked before the input of the same edge is predicted, so
      // a result can never be matched against an item accepted with it.
      if (out_valid_i && !out_stall_i) begin
        seen = {out_byte_i, last_i, truncated_i};
        if (expected_chars.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("unexpected output: byte %h last %b truncated %b",
                     out_byte_i, last_i, truncated_i);
        end else begin
          want = expected_chars.pop_front();
          if (seen !== want) begin
            fail_count_o++;
            if (fail_count_o <= MAX_REPORTS)
              $display({"mismatch: expected byte %h last %b truncated %b, ",
                        "got byte %h last %b truncated %b"},
                       want.ch, want.last, want.trunc, seen.ch, seen.last, seen.trunc);
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict(cmd_e'(cmd_i), data_byte_i);
      pending_o <= expected_chars.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for banned_word_masker: directed cases, then random dictionary
// loads and text with random gaps on both channels; the verdict comes from bwm_checker.
// Depends on bwm_pkg, banned_word_masker and bwm_checker.
module tb;
  import bwm_pkg::*;

  localparam int unsigned MAX_TOKEN_LEN = 32;
  localparam int unsigned MAX_WORDS     = 16;
  localparam int unsigned MAX_WORD_LEN  = 32;
  localparam int unsigned ITEMS         = 280;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  // Worst scan of a full dictionary plus one longest run.
  localparam int unsigned SETTLE_CYCLES =
    2 * MAX_WORDS * (1 + MAX_WORD_LEN) + 2 * MAX_TOKEN_LEN + 8;
  localparam logic [7:0] CH_A = 8'h61;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  cmd_e        cmd       = CMD_TEXT;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last;
  logic        truncated;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned rx_wait = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;

  // Word under construction, and the bench's record of committed words.
  logic [7:0]  word_buf [64];
  int unsigned word_n;
  logic [7:0]  bank_bytes [MAX_WORDS][64];
  int unsigned bank_len [MAX_WORDS];
  int unsigned bank_n = 0;
  int unsigned items_sent = 0;

  banned_word_masker #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .MAX_WORDS    (MAX_WORDS),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .cmd_i      (cmd),
    .data_byte_i(data_byte),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_byte_o (out_byte),
    .last_o     (last),
    .truncated_o(truncated)
  );

  bwm_checker #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .MAX_WORDS    (MAX_WORDS),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .cmd_i       (cmd),
    .data_byte_i (data_byte),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_byte_i  (out_byte),
    .last_i      (last),
    .truncated_i (truncated),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // The receiver draws a stall length after every output transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned gap;
    if (!rst_ni) begin
      rx_wait   <= 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      gap = rx_quiet ? 0 : $urandom_range(0, 15);
      rx_wait   <= gap;
      out_stall <= (gap != 0);
    end else if (rx_wait != 0) begin
      rx_wait   <= rx_wait - 1;
      out_stall <= (rx_wait > 1);
    end
  end

  function automatic logic [7:0] pick_letter();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) return CH_A + 8'($urandom_range(0, 3));
    do b = 8'($urandom_range(0, 255));
    while (b inside {CH_SPACE, CH_COMMA, CH_PERIOD, CH_HYPHEN});
    return b;
  endfunction

  function automatic logic [7:0] pick_delim();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_COMMA;
      2:       return CH_PERIOD;
      default: return CH_HYPHEN;
    endcase
  endfunction

  // Mostly short words, now and then exactly the limit or past it.
  function automatic int unsigned pick_len(input int unsigned max_len);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return max_len + $urandom_range(1, 8);
    if (r < 8) return max_len;
    return $urandom_range(1, 5);
  endfunction

  task automatic fill_random(input int unsigned len);
    int unsigned i;
    word_n = len;
    for (i = 0; i < len; i++) word_buf[i] = pick_letter();
  endtask

  task automatic send_item(input cmd_e c, input logic [7:0] b);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    data_byte <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    // Dictionary commands after the dictionary is full are ignored by the block.
    if (!(bank_n >= MAX_WORDS && c inside {CMD_DICT, CMD_COMMIT})) items_sent++;
  endtask

  task automatic send_text();
    int unsigned i;
    for (i = 0; i < word_n; i++) send_item(CMD_TEXT, word_buf[i]);
  endtask

  task automatic load_word(input bit mix);
    int unsigned i;
    for (i = 0; i < word_n; i++) begin
      if (mix && $urandom_range(0, 9) == 0) send_item(CMD_TEXT, pick_letter());
      send_item(CMD_DICT, word_buf[i]);
    end
    send_item(CMD_COMMIT, 8'($urandom_range(0, 255)));
    if (bank_n < MAX_WORDS) begin
      for (i = 0; i < word_n; i++) bank_bytes[bank_n][i] = word_buf[i];
      bank_len[bank_n] = word_n;
      bank_n++;
    end
  endtask

  // Most tokens repeat a stored word, some with a changed or missing last byte.
  task automatic make_token();
    int unsigned r;
    int unsigned src;
    int unsigned i;
    r = $urandom_range(0, 99);
    if (bank_n != 0 && r < 60) begin
      src = $urandom_range(0, bank_n - 1);
      word_n = bank_len[src];
      for (i = 0; i < word_n; i++) word_buf[i] = bank_bytes[src][i];
      if (word_n > MAX_TOKEN_LEN && $urandom_range(0, 1) == 1) word_n = MAX_TOKEN_LEN;
      if (r >= 45 && word_n != 0) begin
        if (word_n > 1 && $urandom_range(0, 1) == 1) word_n--;
        else word_buf[word_n - 1] = pick_letter();
      end
      if (word_n == 0) fill_random(1);
    end else begin
      fill_random(pick_len(MAX_TOKEN_LEN));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned r;
    bit overflow_tried;
    overflow_tried = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Delimiters and an end of text with no open token produce nothing.
    send_item(CMD_TEXT, CH_COMMA);
    send_item(CMD_TEXT, CH_SPACE);
    send_item(CMD_END, 8'hFF);
    // An empty dictionary word is stored but can never match.
    word_n = 0;
    load_word(1'b0);
    // Extreme byte values; the zero byte is an ordinary character.
    word_n = 2;
    word_buf[0] = 8'h00;
    word_buf[1] = 8'hFF;
    load_word(1'b0);
    send_text();
    send_item(CMD_TEXT, CH_PERIOD);
    word_n = 1;
    send_text();
    send_item(CMD_TEXT, CH_HYPHEN);
    send_item(CMD_TEXT, CH_HYPHEN);
    // A word committed between two tokens only affects the second one.
    word_n = 2;
    word_buf[0] = CH_A;
    word_buf[1] = CH_A + 8'd1;
    send_text();
    send_item(CMD_TEXT, CH_SPACE);
    load_word(1'b0);
    send_text();
    send_item(CMD_END, 8'h00);
    word_n = 1;
    word_buf[0] = 8'hFF;
    send_text();
    send_item(CMD_END, 8'h55);
    drain();

    while (items_sent < ITEMS) begin
      if ($urandom_range(0, 9) == 0) tx_quiet = !tx_quiet;
      if ($urandom_range(0, 9) == 0) rx_quiet <= !rx_quiet;
      if ($urandom_range(0, 29) == 0) drain();
      r = $urandom_range(0, 99);
      if (bank_n < MAX_WORDS && (items_sent >= ITEMS / 2 || r < 20)) begin
        // One word of exactly the limit and one past it are always loaded.
        case (bank_n)
          3:       fill_random(MAX_WORD_LEN);
          5:       fill_random(MAX_WORD_LEN + 3);
          default: fill_random(pick_len(MAX_WORD_LEN));
        endcase
        load_word(1'b1);
      end else if (bank_n == MAX_WORDS && !overflow_tried) begin
        overflow_tried = 1'b1;
        fill_random(3);
        load_word(1'b1);
      end else if (r < 28) begin
        repeat ($urandom_range(1, 4))
          send_item($urandom_range(0, 1) ? CMD_TEXT : CMD_END, 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 2)) send_item(CMD_TEXT, pick_delim());
        make_token();
        send_text();
        if ($urandom_range(0, 6) == 0) send_item(CMD_END, 8'($urandom_range(0, 255)));
        else repeat ($urandom_range(1, 3)) send_item(CMD_TEXT, pick_delim());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
